/* sv/hts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes of the hierarchical state machine transition sequencer.
// Depends on nothing; imported by hsm_transition_sequencer.

package hts_pkg;

    // Field widths of one input beat and one result beat.
    localparam int ID_W     = 8;
    localparam int MODE_W   = 2;
    localparam int ACT_W    = 2;
    localparam int LVL_W    = 4;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 16;

    // Ancestor walks stop after this many steps; the counter holds the limit itself.
    localparam int WALK_W     = 9;
    localparam int WALK_LIMIT = 256;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    // Result actions.
    localparam logic [ACT_W-1:0] ACT_ENTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EXIT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DONE  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_EXIT,
        ST_CHAIN,
        ST_REEXIT,
        ST_ENTER,
        ST_DONE
    } hts_state_t;

endpackage

/* sv/hts_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the parent table.

module hts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/hsm_transition_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the hierarchical state machine transition sequencer.
// Depends on hts_pkg and on hts_ram for the parent table.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tdata: mode, target_id, parent_id
//  m_        out        m_tvalid/m_tready   m_tdata: action, state_id, level, overflow;
//                                            m_tlast: final beat of an item
//
// One item is taken at a time. A stop emits one exit per active state. A transition to
// any state but the innermost walks the parent table one ancestor per cycle through the
// table's read port, once to find the shared ancestor and once to build the entry chain
// (each up to 256 steps), then emits its exits and then its entries.
// After reset a clearing pass writes zero to every table entry, during which no input
// beat is taken. A stalled result beat holds the sequencer.

module hsm_transition_sequencer #(
    parameter int MAX_DEPTH  = 8,
    parameter int NUM_STATES = 256
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata, from bit 0: mode[1:0], target_id[9:2], parent_id[17:10], zero fill.
    input  logic [hts_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata, from bit 0: action[1:0], state_id[9:2], level[13:10], overflow[14],
    // zero fill.
    output logic [hts_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast
);

    import hts_pkg::*;

    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(NUM_STATES);
    localparam int IW = (AW > ID_W) ? AW : ID_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_STATES - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_DEPTH);

    // Control registers.
    hts_state_t      state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // Working registers of the current item.
    logic [ID_W-1:0]   target_reg, target_next;
    logic              cut_reg, cut_next;
    logic [WALK_W-1:0] steps_reg, steps_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     best_reg, best_next;
    logic [ID_W-1:0]   shared_reg, shared_next;
    logic [CW-1:0]     floor_reg, floor_next;
    logic              chain_reg, chain_next;
    logic              first_reg, first_next;
    logic [WALK_W-1:0] n_reg, n_next;
    logic              rng_reg, rng_next;
    logic [ID_W-1:0]   stk_reg [MAX_DEPTH];
    logic [ID_W-1:0]   stk_next [MAX_DEPTH];
    logic [ID_W-1:0]   sh_reg [MAX_DEPTH];
    logic [ID_W-1:0]   sh_next [MAX_DEPTH];
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    // Parent table port signals.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ID_W-1:0]   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [ID_W-1:0]   ram_rdata;
    logic [ID_W-1:0]   rd_id;
    logic [IW-1:0]     rd_ext;
    logic [IW-1:0]     wr_ext;

    // Decoded and derived signals.
    logic              s_accept;
    logic              out_free;
    logic [MODE_W-1:0] in_mode;
    logic [ID_W-1:0]   in_target;
    logic [ID_W-1:0]   in_parent;
    logic              in_range;
    logic [SW-1:0]     top_idx;
    logic [ID_W-1:0]   top_id;
    logic              in_top_hit;
    logic [ID_W-1:0]   par;
    logic              find_end;
    logic [ID_W-1:0]   chain_cur;
    logic              chain_go;
    logic              hit_any;
    logic [SW-1:0]     hit_idx;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign in_mode   = s_tdata[1:0];
    assign in_target = s_tdata[9:2];
    assign in_parent = s_tdata[17:10];
    assign in_range  = (32'(in_target) < 32'(NUM_STATES));

    // Innermost active state.
    assign top_idx    = SW'(cnt_reg - CW'(1));
    assign top_id     = stk_reg[top_idx];
    assign in_top_hit = (cnt_reg != '0) && (top_id == in_target);

    // Parent read back from the table; ids beyond the table have the top level as parent.
    assign par      = rng_reg ? ram_rdata : '0;
    assign find_end = (par == '0) || steps_reg[WALK_W-1];

    // Entry chain walk: the target first, then its ancestors up to the innermost state.
    assign chain_cur = first_reg ? target_reg : par;
    assign chain_go  = (chain_cur != '0) && !((cnt_reg != '0) && (chain_cur == top_id))
                       && !n_reg[WALK_W-1];

    // Table address conversion.
    assign rd_ext    = IW'(rd_id);
    assign wr_ext    = IW'(in_target);
    assign ram_raddr = rd_ext[AW-1:0];

    // Deepest active entry that matches the current ancestor.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int j = 0; j < MAX_DEPTH; j++) begin
            if ((CW'(j) < cnt_reg) && (stk_reg[j] == par)) begin
                hit_any = 1'b1;
                hit_idx = SW'(j);
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (in_mode == MODE_TRANS && in_target != '0) begin
                        state_next = in_top_hit ? ST_REEXIT : ST_FIND;
                    end else if (in_mode == MODE_TRANS || in_mode == MODE_STOP) begin
                        state_next = ST_EXIT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIND: begin
                if (find_end) begin
                    state_next = ST_EXIT;
                end
            end
            ST_EXIT: begin
                if (cnt_reg <= floor_reg) begin
                    state_next = chain_reg ? ST_CHAIN : ST_DONE;
                end
            end
            ST_CHAIN: begin
                if (!chain_go) begin
                    state_next = ST_ENTER;
                end
            end
            ST_REEXIT: begin
                if (out_free) begin
                    state_next = ST_ENTER;
                end
            end
            ST_ENTER: begin
                if (n_reg == '0 || cnt_reg == CNT_FULL) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, table port and result beats.
    always_comb begin
        logic              emit;
        logic [ACT_W-1:0]  e_act;
        logic [ID_W-1:0]   e_id;
        logic [LVL_W-1:0]  e_lvl;
        logic              e_ovf;
        logic              e_last;

        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        target_next = target_reg;
        cut_next    = cut_reg;
        steps_next  = steps_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        shared_next = shared_reg;
        floor_next  = floor_reg;
        chain_next  = chain_reg;
        first_next  = first_reg;
        n_next      = n_reg;
        stk_next    = stk_reg;
        sh_next     = sh_reg;
        ram_we      = 1'b0;
        ram_waddr   = clr_reg;
        ram_wdata   = '0;
        rd_id       = '0;
        emit        = 1'b0;
        e_act       = ACT_DONE;
        e_id        = '0;
        e_lvl       = '0;
        e_ovf       = 1'b0;
        e_last      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                // Clearing pass over the parent table.
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                // Start the parent read of the target, so the ancestor walk can begin.
                rd_id = in_target;
                if (s_accept) begin
                    target_next = in_target;
                    cut_next    = 1'b0;
                    steps_next  = '0;
                    found_next  = 1'b0;
                    floor_next  = '0;
                    chain_next  = 1'b0;
                    first_next  = 1'b1;
                    n_next      = '0;
                    if (in_mode == MODE_LOAD && in_target != '0 && in_range) begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_ext[AW-1:0];
                        ram_wdata = in_parent;
                    end
                end
            end
            ST_FIND: begin
                // One ancestor a cycle, compared against every active state at once.
                if (find_end) begin
                    if (found_reg) begin
                        floor_next = CW'(best_reg) + CW'(1);
                        chain_next = (shared_reg != target_reg);
                    end else begin
                        floor_next = '0;
                        chain_next = 1'b1;
                    end
                end else begin
                    rd_id      = par;
                    steps_next = steps_reg + WALK_W'(1);
                    if (hit_any && (!found_reg || hit_idx > best_reg)) begin
                        found_next  = 1'b1;
                        best_next   = hit_idx;
                        shared_next = par;
                    end
                end
            end
            ST_EXIT: begin
                // Exit the innermost state until the floor is reached.
                if (cnt_reg > floor_reg && out_free) begin
                    emit     = 1'b1;
                    e_act    = ACT_EXIT;
                    e_id     = top_id;
                    e_lvl    = LVL_W'(top_idx);
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_CHAIN: begin
                // Push each chain state; the line keeps the outermost ones at the front.
                if (chain_go) begin
                    rd_id      = chain_cur;
                    first_next = 1'b0;
                    n_next     = n_reg + WALK_W'(1);
                    sh_next[0] = chain_cur;
                    for (int j = 1; j < MAX_DEPTH; j++) begin
                        sh_next[j] = sh_reg[j-1];
                    end
                end
            end
            ST_REEXIT: begin
                // Target is the innermost state: exit it, then enter it once more.
                if (out_free) begin
                    emit       = 1'b1;
                    e_act      = ACT_EXIT;
                    e_id       = top_id;
                    e_lvl      = LVL_W'(top_idx);
                    cnt_next   = cnt_reg - CW'(1);
                    sh_next[0] = target_reg;
                    n_next     = WALK_W'(1);
                end
            end
            ST_ENTER: begin
                // Enter the chain outermost first while the stack has room.
                if (n_reg != '0) begin
                    if (cnt_reg == CNT_FULL) begin
                        cut_next = 1'b1;
                    end else if (out_free) begin
                        emit     = 1'b1;
                        e_act    = ACT_ENTER;
                        e_id     = sh_reg[0];
                        e_lvl    = LVL_W'(cnt_reg);
                        stk_next[cnt_reg[SW-1:0]] = sh_reg[0];
                        cnt_next = cnt_reg + CW'(1);
                        n_next   = n_reg - WALK_W'(1);
                        for (int j = 0; j < MAX_DEPTH - 1; j++) begin
                            sh_next[j] = sh_reg[j+1];
                        end
                        sh_next[MAX_DEPTH-1] = '0;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_act  = ACT_DONE;
                    e_ovf  = cut_reg;
                    e_last = 1'b1;
                end
            end
            default: begin
            end
        endcase

        rng_next = (32'(rd_id) < 32'(NUM_STATES));

        // Output register: load a new beat, or drop the one just taken.
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, e_ovf, e_lvl, e_id, e_act};
            m_tlast_next  = e_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Parent table.
    hts_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_STATES)
    ) u_parent_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        target_reg  <= target_next;
        cut_reg     <= cut_next;
        steps_reg   <= steps_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        shared_reg  <= shared_next;
        floor_reg   <= floor_next;
        chain_reg   <= chain_next;
        first_reg   <= first_next;
        n_reg       <= n_next;
        rng_reg     <= rng_next;
        stk_reg     <= stk_next;
        sh_reg      <= sh_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

/* sim/tb_hsm_transition_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hsm_transition_sequencer: a clocked driver and monitor,
// a predictor of the parent table and active stack, and directed plus random items.
// Depends on hts_pkg and the hsm_transition_sequencer RTL.

module tb_hsm_transition_sequencer;
    import hts_pkg::*;

    localparam int MAX_DEPTH  = 8;
    localparam int NUM_STATES = 256;
    localparam int RAND_ITEMS = 275;
    localparam int ID_POOL    = 40;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 500;
    localparam int MAX_SHOWN  = 10;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One result beat as the block presents it; the first field is the most significant.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  state_id;
        logic [LVL_W-1:0] level;
        logic             overflow;
        logic             last;
    } seq_beat_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    // Stimulus waiting to be offered and result beats still owed by the block.
    logic [IN_W-1:0] stim_items [$];
    seq_beat_t       pending_results [$];

    // Predictor copy of the parent table and the active stack.
    logic [ID_W-1:0] parent_tbl [0:NUM_STATES-1];
    logic [ID_W-1:0] active_stk [0:MAX_DEPTH-1];
    int              active_cnt;

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  beats_seen     = 0;
    int  mismatch_count = 0;
    int  n_load = 0, n_trans = 0, n_stop = 0, n_unused = 0, n_cut = 0, peak_depth = 0;
    int  drv_gap = 0, drv_tick = 0, mon_gap = 0, mon_tick = 0, hold_cnt = 0;
    bit  drv_calm = 1'b0, mon_calm = 1'b0, hold_done = 1'b0;
    logic hold_off = 1'b0;

    hsm_transition_sequencer #(
        .MAX_DEPTH  (MAX_DEPTH),
        .NUM_STATES (NUM_STATES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void owe_beat(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                                     input int lvl, input logic ovf, input logic lst);
        seq_beat_t b;
        b.action   = act;
        b.state_id = id;
        b.level    = lvl[LVL_W-1:0];
        b.overflow = ovf;
        b.last     = lst;
        pending_results.push_back(b);
    endfunction

    function automatic void leave_innermost();
        if (active_cnt > 0) begin
            active_cnt--;
            owe_beat(ACT_EXIT, active_stk[active_cnt], active_cnt, 1'b0, 1'b0);
            active_stk[active_cnt] = '0;
        end
    endfunction

    function automatic void leave_all();
        while (active_cnt > 0)
            leave_innermost();
    endfunction

    // Pushes a state if the stack has room; a full stack refuses it.
    function automatic logic enter_one(input logic [ID_W-1:0] id);
        if (active_cnt >= MAX_DEPTH)
            return 1'b0;
        active_stk[active_cnt] = id;
        owe_beat(ACT_ENTER, id, active_cnt, 1'b0, 1'b0);
        active_cnt++;
        if (active_cnt > peak_depth)
            peak_depth = active_cnt;
        return 1'b1;
    endfunction

    // Walks up from the target to the innermost active state (or to the top level) and
    // enters that chain outermost first; returns 1 when entries did not fit.
    function automatic logic enter_chain(input logic [ID_W-1:0] tgt);
        logic [ID_W-1:0] chain [0:WALK_LIMIT-1];
        int              n;
        logic            have_inner;
        logic [ID_W-1:0] inner;
        logic [ID_W-1:0] id;
        logic            cut;
        n          = 0;
        have_inner = active_cnt > 0;
        inner      = have_inner ? active_stk[active_cnt-1] : '0;
        id         = tgt;
        cut        = 1'b0;
        while (id != 0 && !(have_inner && id == inner) && n < WALK_LIMIT) begin
            chain[n] = id;
            n++;
            id = parent_tbl[id];
        end
        while (n > 0) begin
            n--;
            if (!enter_one(chain[n]))
                cut = 1'b1;
        end
        return cut;
    endfunction

    // Works out every result beat that one accepted input beat causes.
    function automatic void sequence_item(input logic [IN_W-1:0] word);
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   tgt;
        logic [ID_W-1:0]   par;
        logic [ID_W-1:0]   walk;
        logic              cut;
        int                shared_idx;
        int                steps;
        mode = word[1:0];
        tgt  = word[9:2];
        par  = word[17:10];
        cut  = 1'b0;
        if (mode == MODE_LOAD) begin
            n_load++;
            if (tgt != 0)
                parent_tbl[tgt] = par;
        end else if (mode == MODE_STOP || (mode == MODE_TRANS && tgt == 0)) begin
            n_stop++;
            leave_all();
        end else if (mode == MODE_TRANS) begin
            n_trans++;
            if (active_cnt > 0 && active_stk[active_cnt-1] == tgt) begin
                leave_innermost();
                void'(enter_one(tgt));
            end else begin
                // Deepest active state that is a proper ancestor of the target.
                shared_idx = -1;
                for (int i = active_cnt - 1; i >= 0 && shared_idx < 0; i--) begin
                    walk  = parent_tbl[tgt];
                    steps = 0;
                    while (walk != 0 && steps < WALK_LIMIT && shared_idx < 0) begin
                        if (walk == active_stk[i])
                            shared_idx = i;
                        walk = parent_tbl[walk];
                        steps++;
                    end
                end
                if (shared_idx >= 0) begin
                    while (active_cnt > shared_idx + 1)
                        leave_innermost();
                    if (active_stk[shared_idx] != tgt)
                        cut = enter_chain(tgt);
                end else begin
                    leave_all();
                    cut = enter_chain(tgt);
                end
            end
        end else begin
            n_unused++;
        end
        if (cut)
            n_cut++;
        owe_beat(ACT_DONE, '0, 0, cut, 1'b1);
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    // Mostly short gaps, a few long ones, none at all in calm phases.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers queued items one beat at a time and predicts each one as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            drv_tick++;
            if (drv_tick % 97 == 0)
                drv_calm = ($urandom_range(0, 3) == 0);
            if (s_tvalid && s_tready) begin
                sequence_item(s_tdata);
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (stim_items.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stim_items.pop_front();
                    drv_gap  = pick_gap(drv_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Once, well into the run, the receiver refuses all beats for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off <= 1'b0;
        end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) begin
                hold_off  <= 1'b0;
                hold_done = 1'b1;
            end else begin
                hold_off <= 1'b1;
            end
        end
    end

    // Checks each accepted result beat against the oldest owed one and paces m_tready.
    always @(posedge aclk) begin
        seq_beat_t got;
        seq_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            mon_tick++;
            if (mon_tick % 89 == 0)
                mon_calm = ($urandom_range(0, 3) == 0);
            if (m_tvalid && m_tready) begin
                beats_seen++;
                got = {m_tdata[1:0], m_tdata[9:2], m_tdata[13:10], m_tdata[14], m_tlast};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("%0t: result beat with none owed:", $realtime,
                                 " act %0d id %0d lvl %0d ovf %0b last %0b",
                                 got.action, got.state_id, got.level,
                                 got.overflow, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                            $display("%0t: mismatch: expected", $realtime,
                                     " act %0d id %0d lvl %0d ovf %0b last %0b,",
                                     want.action, want.state_id, want.level,
                                     want.overflow, want.last,
                                     " got act %0d id %0d lvl %0d ovf %0b last %0b",
                                     got.action, got.state_id, got.level,
                                     got.overflow, got.last);
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    mon_gap = pick_gap(mon_calm);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] tgt,
                              input logic [ID_W-1:0] par);
        stim_items.push_back({{(IN_W-18){1'b0}}, par, tgt, mode});
        items_queued++;
    endtask

    initial begin
        int r, n_rand, waited;
        logic [ID_W-1:0] tgt;
        logic [ID_W-1:0] par;
        logic [MODE_W-1:0] mode;

        for (int i = 0; i < NUM_STATES; i++)
            parent_tbl[i] = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
            active_stk[i] = '0;
        active_cnt = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored items, stops on an empty stack, a chain deeper than the stack,
        // partial exits, re-entry of the innermost state, a self-parented state, a target
        // that is its own active ancestor, and a full swap of the stack.
        queue_item(MODE_UNUSED, 8'hFF, 8'hFF);
        queue_item(MODE_LOAD, 8'h00, 8'hFF);
        queue_item(MODE_TRANS, 8'h00, 8'h00);
        queue_item(MODE_STOP, 8'h00, 8'h00);
        for (int k = 2; k <= 10; k++)
            queue_item(MODE_LOAD, k[7:0], 8'(k - 1));
        queue_item(MODE_TRANS, 8'd10, 8'h00);
        queue_item(MODE_TRANS, 8'd4, 8'h00);
        queue_item(MODE_TRANS, 8'd3, 8'h00);
        queue_item(MODE_TRANS, 8'd3, 8'h00);
        queue_item(MODE_LOAD, 8'd31, 8'd30);
        queue_item(MODE_TRANS, 8'd31, 8'h00);
        queue_item(MODE_LOAD, 8'd30, 8'd30);
        queue_item(MODE_TRANS, 8'd30, 8'h00);
        queue_item(MODE_LOAD, 8'hFF, 8'hFF);
        queue_item(MODE_TRANS, 8'hFF, 8'h00);
        queue_item(MODE_TRANS, 8'd10, 8'h00);
        queue_item(MODE_STOP, 8'h00, 8'h00);

        // Random: mostly tree building and transitions over a small pool of ids, with
        // parents taken from lower ids so most chains are acyclic; the rest is noise.
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            r    = $urandom_range(0, 99);
            tgt  = 8'($urandom_range(1, ID_POOL));
            par  = 8'($urandom_range(0, 255));
            mode = MODE_TRANS;
            if (r < 25) begin
                mode = MODE_LOAD;
                if (tgt == 1 || $urandom_range(0, 4) == 0)
                    par = '0;
                else if ($urandom_range(0, 19) == 0)
                    par = 8'($urandom_range(1, ID_POOL));
                else
                    par = 8'($urandom_range(tgt - 1, (tgt > 6) ? tgt - 6 : 1));
            end else if (r < 80) begin
                if ($urandom_range(0, 19) == 0)
                    tgt = 8'($urandom_range(0, 255));
            end else if (r < 87) begin
                mode = MODE_STOP;
                tgt  = 8'($urandom_range(0, 255));
            end else if (r < 92) begin
                tgt = '0;
            end else if (r < 96) begin
                mode = MODE_UNUSED;
                tgt  = 8'($urandom_range(0, 255));
            end else begin
                mode = MODE_LOAD;
                tgt  = 8'($urandom_range(0, 255));
            end
            queue_item(mode, tgt, par);
            if (!(mode == MODE_UNUSED || (mode == MODE_LOAD && tgt == 0)))
                n_rand++;
        end

        // Wait for every item to be taken and every owed beat to arrive.
        while (items_accepted < items_queued)
            @(posedge aclk);
        waited = 0;
        while (pending_results.size() > 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (64) @(posedge aclk);
        if (pending_results.size() > 0) begin
            $display("%0d result beats were owed but never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("Ran %0d items: %0d loads, %0d transitions, %0d stops, %0d unused modes.",
                 items_accepted, n_load, n_trans, n_stop, n_unused);
        $display("Checked %0d result beats; deepest stack %0d, %0d cut chains, %0d mismatches.",
                 beats_seen, peak_depth, n_cut, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Safety net in case the block hangs.
    initial begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/hts_pkg.sv
sv/hts_ram.sv
sv/hsm_transition_sequencer.sv
sim/tb_hsm_transition_sequencer.sv
